// ===== rtl/accel_decel_slew_limiter_defines.svh =====
`ifndef ACCEL_DECEL_SLEW_LIMITER_DEFINES_SVH
`define ACCEL_DECEL_SLEW_LIMITER_DEFINES_SVH

`define ADSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slew limiter check failed in the same cycle");

`define ADSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slew limiter check failed in the next cycle");

`endif

// ===== rtl/adsl_pkg.sv =====
package adsl_pkg;

    localparam int SPEED_W   = 32;
    localparam int STEP_W    = 31;
    localparam int CFG_IDX_W = 2;

    typedef logic signed [SPEED_W-1:0] t_speed;
    typedef logic [STEP_W-1:0]         t_step;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_STEP  = 2'd0,
        CFG_DECEL_STEP  = 2'd1,
        CFG_SPEED_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_step accel_step;
        t_step decel_step;
    } t_ramp_cfg;

endpackage

// ===== rtl/accel_decel_slew_limiter.sv =====
// Path: a beat accepted into the input register passes through the ramp into the result register.
// Throughput: one beat per cycle unless the output stalls; the speed register
// updates in the same cycle as the result register, so the next input beat sees it.
// Reset clears the three step and limit registers, the kept speed and both
// valid flags; no result beat is pending after reset.
module accel_decel_slew_limiter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  adsl_pkg::t_speed                 i_target_speed,
    output logic                             o_valid,
    input  logic                             i_ready,
    output adsl_pkg::t_speed                 o_ramped_speed,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [adsl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  adsl_pkg::t_step                  i_cfg_data
);

    `include "accel_decel_slew_limiter_defines.svh"

    adsl_pkg::t_ramp_cfg               r_cfg;
    adsl_pkg::t_step                   r_speed_limit;
    logic                              r_in_valid;
    adsl_pkg::t_speed                  r_tgt;
    logic                              r_out_valid;
    adsl_pkg::t_speed                  r_out;
    adsl_pkg::t_speed                  r_cur_speed;

    logic                              w_advance;
    logic signed [adsl_pkg::SPEED_W:0] w_tgt_ext;
    logic signed [adsl_pkg::SPEED_W:0] w_lim;
    logic signed [adsl_pkg::SPEED_W:0] w_neg_lim;
    adsl_pkg::t_speed                  n_tgt;
    adsl_pkg::t_speed                  w_next;

    assign w_advance   = !r_out_valid || i_ready;
    assign o_ready     = !r_in_valid || w_advance;
    assign o_valid     = r_out_valid;
    assign o_ramped_speed = r_out;
    assign o_cfg_ready = 1'b1;

    // The target is clamped on the way into the input register.
    assign w_tgt_ext = {i_target_speed[adsl_pkg::SPEED_W-1], i_target_speed};
    assign w_lim     = $signed({2'b00, r_speed_limit});
    assign w_neg_lim = -w_lim;

    always_comb begin
        if (w_tgt_ext > w_lim) begin
            n_tgt = w_lim[adsl_pkg::SPEED_W-1:0];
        end else if (w_tgt_ext < w_neg_lim) begin
            n_tgt = w_neg_lim[adsl_pkg::SPEED_W-1:0];
        end else begin
            n_tgt = i_target_speed;
        end
    end

    adsl_ramp u_ramp (
        .i_target  (r_tgt),
        .i_current (r_cur_speed),
        .i_cfg     (r_cfg),
        .o_next    (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg         <= '0;
            r_speed_limit <= '0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cur_speed   <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (adsl_pkg::t_cfg_idx'(i_cfg_index))
                    adsl_pkg::CFG_ACCEL_STEP:  r_cfg.accel_step <= i_cfg_data;
                    adsl_pkg::CFG_DECEL_STEP:  r_cfg.decel_step <= i_cfg_data;
                    adsl_pkg::CFG_SPEED_LIMIT: r_speed_limit    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_cur_speed <= w_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tgt <= n_tgt;
        end
        if (w_advance && r_in_valid) begin
            r_out <= w_next;
        end
    end

    `ADSL_ASSERT_SAME(a_out_matches_state, i_clk, i_rst_n,
        r_out_valid, r_out == r_cur_speed)
    `ADSL_ASSERT_NEXT(a_state_holds_on_stall, i_clk, i_rst_n,
        r_out_valid && !i_ready, $stable(r_cur_speed))
    `ADSL_ASSERT_SAME(a_full_blocks_input, i_clk, i_rst_n,
        r_in_valid && r_out_valid && !i_ready, !o_ready)

endmodule

// ===== rtl/adsl_ramp.sv =====
module adsl_ramp (
    input  adsl_pkg::t_speed    i_target,
    input  adsl_pkg::t_speed    i_current,
    input  adsl_pkg::t_ramp_cfg i_cfg,
    output adsl_pkg::t_speed    o_next
);

    logic                              w_fwd;
    logic                              w_acc;
    adsl_pkg::t_step                   w_step_mag;
    logic signed [adsl_pkg::SPEED_W:0] w_diff;
    logic [adsl_pkg::SPEED_W:0]        w_gap;
    logic [adsl_pkg::SPEED_W-1:0]      w_cur_mag;
    logic signed [adsl_pkg::SPEED_W+1:0] w_step_ext;
    logic signed [adsl_pkg::SPEED_W+1:0] w_sum;
    logic signed [adsl_pkg::SPEED_W+1:0] w_ramp;
    logic signed [adsl_pkg::SPEED_W+1:0] w_max;
    logic signed [adsl_pkg::SPEED_W+1:0] w_min;

    assign w_fwd = (i_current > $signed({adsl_pkg::SPEED_W{1'b0}}));
    assign w_acc = w_fwd ? (i_target >= i_current) : (i_target <= i_current);
    assign w_step_mag = w_acc ? i_cfg.accel_step : i_cfg.decel_step;

    assign w_diff = {i_target[adsl_pkg::SPEED_W-1], i_target}
                  - {i_current[adsl_pkg::SPEED_W-1], i_current};
    assign w_gap = w_diff[adsl_pkg::SPEED_W] ? $unsigned(-w_diff) : $unsigned(w_diff);

    assign w_cur_mag = i_current[adsl_pkg::SPEED_W-1] ? $unsigned(-i_current)
                                                      : $unsigned(i_current);

    assign w_step_ext = w_acc ? $signed({3'b000, w_step_mag})
                              : -$signed({3'b000, w_step_mag});
    assign w_sum  = $signed({2'b00, w_cur_mag}) + w_step_ext;
    assign w_ramp = w_fwd ? w_sum : -w_sum;

    assign w_max = $signed({3'b000, {(adsl_pkg::SPEED_W-1){1'b1}}});
    assign w_min = $signed({3'b111, {(adsl_pkg::SPEED_W-1){1'b0}}});

    always_comb begin
        if (w_gap < {2'b00, w_step_mag}) begin
            o_next = i_target;
        end else if (w_ramp > w_max) begin
            o_next = w_max[adsl_pkg::SPEED_W-1:0];
        end else if (w_ramp < w_min) begin
            o_next = w_min[adsl_pkg::SPEED_W-1:0];
        end else begin
            o_next = w_ramp[adsl_pkg::SPEED_W-1:0];
        end
    end

endmodule
